>>> rtl/kot_pkg.sv
// Shared constants and types for the keyed overflow table.
package kot_pkg;

	// Default sizes of the table.
	localparam int DEF_TABLE_DEPTH   = 64;
	localparam int DEF_KEY_WIDTH     = 64;
	localparam int DEF_PAYLOAD_WIDTH = 64;

	// Fixed widths of the request and result fields.
	localparam int FIELD_W  = 64;
	localparam int COUNT_W  = 7;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Operation codes.
	localparam op_t OP_ADD    = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_LOOKUP = 2'd2;

	// Status codes.
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_MISS = 2'd1;
	localparam status_t ST_FULL = 2'd2;

endpackage

>>> rtl/keyed_overflow_table_core.sv
// Top level of the keyed overflow table: request sequencer around the entry memory.
//
// A bounded table of key/payload entries held in one single-port-read memory.
// An add appends at the newest slot; it is refused with status full when
// TABLE_DEPTH entries are held. A lookup or remove reads the stored keys one
// per cycle from the newest entry toward the oldest, through the single memory
// read port, and stops at the first match or after all held entries on a miss.
// A remove that does not hit the newest entry then reads the newest entry and
// writes it into the freed slot. One request is worked on at a time; a finished
// result waits in the output register while the next request is accepted.
// entry_count reports the held count modulo 128.
module keyed_overflow_table_core import kot_pkg::*; #(
	parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
	parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
	parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [FIELD_W-1:0]  search_key,
	input  logic [FIELD_W-1:0]  entry_payload,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [FIELD_W-1:0]  found_key,
	output logic [FIELD_W-1:0]  found_payload,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADD    = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_RDLAST = 3'd3;
	localparam logic [2:0] S_WRSWAP = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0]               state_q;
	logic [CW-1:0]            count_q;
	op_t                      op_q;
	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [AW-1:0]            issue_idx_q;
	logic                     issue_more_q;
	logic                     valid_s1;
	logic [AW-1:0]            addr_s1;
	logic [AW-1:0]            slot_q;
	status_t                  res_status_q;
	logic [FIELD_W-1:0]       res_key_q;
	logic [FIELD_W-1:0]       res_pay_q;
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [FIELD_W-1:0]       out_key_q;
	logic [FIELD_W-1:0]       out_pay_q;
	logic [COUNT_W-1:0]       out_count_q;

	logic                     accept;
	logic                     full;
	logic [CW-1:0]            count_dec;
	logic [AW-1:0]            last_idx;
	logic [CW+COUNT_W-1:0]    count_ext;
	logic                     match;
	logic                     scan_end_miss;
	logic                     scan_rd;
	logic                     out_free;

	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [EW-1:0]            wr_data;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic [EW-1:0]            rd_data;
	logic [KEY_WIDTH-1:0]     rd_key;
	logic [PAYLOAD_WIDTH-1:0] rd_pay;

	// Handshake and table status.
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign full      = (count_q >= CW'(TABLE_DEPTH));
	assign count_dec = count_q - CW'(1);
	assign last_idx  = count_dec[AW-1:0];
	assign count_ext = {{COUNT_W{1'b0}}, count_q};
	assign out_free  = !out_valid_q || !out_stall;

	// Scan compare: read data lines up with the address issued in the previous cycle.
	assign rd_key        = rd_data[EW-1:PAYLOAD_WIDTH];
	assign rd_pay        = rd_data[PAYLOAD_WIDTH-1:0];
	assign match         = (state_q == S_SCAN) && valid_s1 && (rd_key == key_q);
	assign scan_end_miss = (state_q == S_SCAN) && valid_s1 && !match && (addr_s1 == '0);
	assign scan_rd       = (state_q == S_SCAN) && issue_more_q && !match;

	// Memory port selection.
	always_comb begin
		rd_en   = scan_rd || (state_q == S_RDLAST);
		rd_addr = (state_q == S_RDLAST) ? last_idx : issue_idx_q;
		wr_en   = ((state_q == S_ADD) && !full) || (state_q == S_WRSWAP);
		wr_addr = (state_q == S_WRSWAP) ? slot_q : count_q[AW-1:0];
		wr_data = (state_q == S_WRSWAP) ? rd_data : {key_q, pay_q};
	end

	kot_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Request fields captured at acceptance, plus the scan address and the matched slot.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= search_key[KEY_WIDTH-1:0];
			pay_q <= entry_payload[PAYLOAD_WIDTH-1:0];
		end
		addr_s1 <= issue_idx_q;
		if (match) begin
			slot_q <= addr_s1;
		end
	end

	// Sequencer, held count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			issue_idx_q  <= '0;
			issue_more_q <= 1'b0;
			valid_s1     <= 1'b0;
			res_status_q <= ST_OK;
			res_key_q    <= '0;
			res_pay_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_key_q    <= '0;
			out_pay_q    <= '0;
			out_count_q  <= '0;
		end else begin
			valid_s1 <= scan_rd;
			if (scan_rd) begin
				issue_more_q <= (issue_idx_q != '0);
				issue_idx_q  <= issue_idx_q - AW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_key_q <= '0;
						res_pay_q <= '0;
						case (operation) inside
							OP_ADD: begin
								state_q <= S_ADD;
							end
							OP_REMOVE, OP_LOOKUP: begin
								if (count_q == '0) begin
									res_status_q <= ST_MISS;
									state_q      <= S_EMIT;
								end else begin
									issue_idx_q  <= last_idx;
									issue_more_q <= 1'b1;
									state_q      <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= ST_MISS;
								state_q      <= S_EMIT;
							end
						endcase
					end
				end
				S_ADD: begin
					if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						count_q      <= count_q + CW'(1);
						res_status_q <= ST_OK;
					end
					state_q <= S_EMIT;
				end
				S_SCAN: begin
					if (match) begin
						res_status_q <= ST_OK;
						if (op_q == OP_LOOKUP) begin
							res_key_q <= FIELD_W'(rd_key);
							res_pay_q <= FIELD_W'(rd_pay);
							state_q   <= S_EMIT;
						end else if (addr_s1 == last_idx) begin
							// The newest entry itself goes away: no move needed.
							count_q <= count_dec;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_RDLAST;
						end
					end else if (scan_end_miss) begin
						res_status_q <= ST_MISS;
						state_q      <= S_EMIT;
					end
				end
				S_RDLAST: begin
					state_q <= S_WRSWAP;
				end
				S_WRSWAP: begin
					count_q <= count_dec;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Output register: loads the finished result once the previous one is taken.
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_key_q    <= res_key_q;
				out_pay_q    <= res_pay_q;
				out_count_q  <= count_ext[COUNT_W-1:0];
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign found_key     = out_key_q;
	assign found_payload = out_pay_q;
	assign entry_count   = out_count_q;

endmodule

>>> rtl/kot_ram.sv
// Entry memory of the keyed overflow table: one write port, one registered read port.
module kot_ram import kot_pkg::*; #(
	parameter int DEPTH = DEF_TABLE_DEPTH,
	parameter int WIDTH = DEF_KEY_WIDTH + DEF_PAYLOAD_WIDTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Synchronous write and registered read: read data appears in the cycle after the read is enabled.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> dv/tb_keyed_overflow_table_core.sv
// Self-checking testbench for keyed_overflow_table_core with a table mirror and random traffic.
module tb_keyed_overflow_table_core;
	import kot_pkg::*;

	localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_REQUESTS = 1430;
	localparam int MAX_PRINTED = 40;
	localparam op_t OP_UNUSED = 2'd3;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	// One result of the table as the mirror predicts it.
	typedef struct {
		status_t            st;
		logic [FIELD_W-1:0] fkey;
		logic [FIELD_W-1:0] fpay;
		logic [COUNT_W-1:0] cnt;
	} table_reply_t;

	// Mirror of the entry table: applies each accepted request and checks each result.
	class table_mirror;
		logic [FIELD_W-1:0] key_mem [TABLE_DEPTH];
		logic [FIELD_W-1:0] pay_mem [TABLE_DEPTH];
		int held;
		int accepted;
		int replies;
		int errors;
		table_reply_t due_replies [$];

		function new();
			held = 0;
			accepted = 0;
			replies = 0;
			errors = 0;
		endfunction

		// The newest slot holding the key, or -1 when no held entry matches.
		function int find_newest(logic [FIELD_W-1:0] k);
			for (int i = held - 1; i >= 0; i--) begin
				if (key_mem[i] == k)
					return i;
			end
			return -1;
		endfunction

		function void apply_request(op_t op, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] p);
			table_reply_t r;
			int slot;
			r.st = ST_MISS;
			r.fkey = '0;
			r.fpay = '0;
			case (op)
				OP_ADD: begin
					if (held >= TABLE_DEPTH) begin
						r.st = ST_FULL;
					end else begin
						key_mem[held] = k;
						pay_mem[held] = p;
						held++;
						r.st = ST_OK;
					end
				end
				OP_REMOVE: begin
					slot = find_newest(k);
					if (slot >= 0) begin
						// The newest entry fills the freed slot.
						key_mem[slot] = key_mem[held - 1];
						pay_mem[slot] = pay_mem[held - 1];
						held--;
						r.st = ST_OK;
					end
				end
				OP_LOOKUP: begin
					slot = find_newest(k);
					if (slot >= 0) begin
						r.fkey = key_mem[slot];
						r.fpay = pay_mem[slot];
						r.st = ST_OK;
					end
				end
				default: begin
				end
			endcase
			r.cnt = held[COUNT_W-1:0];
			accepted++;
			due_replies.push_back(r);
		endfunction

		task report_mismatch(string what);
			if (errors < MAX_PRINTED)
				$display("MISMATCH at %0t: result %0d %s", $time, replies, what);
			errors++;
		endtask

		task compare_reply(status_t st, logic [FIELD_W-1:0] fk, logic [FIELD_W-1:0] fp,
				logic [COUNT_W-1:0] cnt);
			table_reply_t w;
			if (due_replies.size() == 0) begin
				report_mismatch("arrived with no request outstanding");
			end else begin
				w = due_replies.pop_front();
				if (st !== w.st)
					report_mismatch($sformatf("status %0d, want %0d", st, w.st));
				if (fk !== w.fkey)
					report_mismatch($sformatf("found_key %h, want %h", fk, w.fkey));
				if (fp !== w.fpay)
					report_mismatch($sformatf("found_payload %h, want %h", fp, w.fpay));
				if (cnt !== w.cnt)
					report_mismatch($sformatf("entry_count %0d, want %0d", cnt, w.cnt));
			end
			replies++;
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	op_t                 operation;
	logic [FIELD_W-1:0]  search_key;
	logic [FIELD_W-1:0]  entry_payload;
	logic                out_valid;
	logic                out_stall;
	status_t             status;
	logic [FIELD_W-1:0]  found_key;
	logic [FIELD_W-1:0]  found_payload;
	logic [COUNT_W-1:0]  entry_count;

	table_mirror mirror;
	int cycles = 0;
	bit no_idle = 1'b0;
	bit hold_off = 1'b0;
	bit rx_stalling = 1'b0;
	int rx_run = 0;
	logic [FIELD_W-1:0] key_pool [8];

	keyed_overflow_table_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.search_key    (search_key),
		.entry_payload (entry_payload),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_key     (found_key),
		.found_payload (found_payload),
		.entry_count   (entry_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [FIELD_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Idle stretch length: mostly short, now and then long.
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	function automatic op_t pick_op(traffic_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:  return r < 85 ? OP_ADD : r < 92 ? OP_LOOKUP : r < 99 ? OP_REMOVE : OP_UNUSED;
			MODE_DRAIN: return r < 15 ? OP_ADD : r < 65 ? OP_REMOVE : r < 97 ? OP_LOOKUP : OP_UNUSED;
			default:    return r < 35 ? OP_ADD : r < 60 ? OP_REMOVE : r < 97 ? OP_LOOKUP : OP_UNUSED;
		endcase
	endfunction

	// Key for a remove or lookup: mostly one that is held, otherwise a likely miss.
	function automatic logic [FIELD_W-1:0] pick_search_key();
		if (mirror.held > 0 && $urandom_range(0, 3) != 0)
			return mirror.key_mem[$urandom_range(0, mirror.held - 1)];
		if ($urandom_range(0, 1) == 0)
			return key_pool[$urandom_range(0, 7)];
		return rand64();
	endfunction

	// Offer one request after an optional gap and wait until the table takes it.
	task automatic send_request(op_t op, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		search_key <= k;
		entry_payload <= p;
		do @(posedge clk); while (in_stall);
		mirror.apply_request(op, k, p);
		@(negedge clk);
	endtask

	// Short hand-picked sequence: empty table, extremes, duplicates, swap on remove.
	task automatic run_directed();
		logic [FIELD_W-1:0] ka;
		logic [FIELD_W-1:0] kb;
		ka = rand64();
		kb = rand64();
		send_request(OP_LOOKUP, ka, rand64());
		send_request(OP_REMOVE, ka, rand64());
		send_request(OP_UNUSED, ka, rand64());
		send_request(OP_ADD, '0, '1);
		send_request(OP_ADD, '1, '0);
		send_request(OP_ADD, ka, rand64());
		send_request(OP_ADD, ka, rand64());
		send_request(OP_LOOKUP, ka, '0);
		send_request(OP_LOOKUP, '0, '1);
		send_request(OP_LOOKUP, '1, '1);
		send_request(OP_LOOKUP, kb, '0);
		send_request(OP_REMOVE, '0, '0);
		send_request(OP_LOOKUP, ka, '1);
		send_request(OP_REMOVE, ka, '0);
		send_request(OP_UNUSED, '1, '1);
		send_request(OP_REMOVE, kb, '1);
		send_request(OP_REMOVE, '1, '0);
		send_request(OP_REMOVE, ka, '1);
		send_request(OP_LOOKUP, ka, '0);
	endtask

	// Random traffic in phases that fill, drain or mix; the first one fills past full.
	task automatic run_random();
		traffic_mode_t mode;
		int run_len;
		int sent;
		op_t op;
		logic [FIELD_W-1:0] k;
		sent = 0;
		mode = MODE_FILL;
		run_len = 100;
		while (sent < RANDOM_REQUESTS) begin
			repeat (run_len) begin
				op = pick_op(mode);
				if (op == OP_ADD)
					k = ($urandom_range(0, 2) == 0) ? key_pool[$urandom_range(0, 7)] : rand64();
				else if (op == OP_UNUSED)
					k = rand64();
				else
					k = pick_search_key();
				send_request(op, k, rand64());
				sent++;
			end
			mode = traffic_mode_t'($urandom_range(0, 2));
			run_len = $urandom_range(20, 120);
			no_idle = ($urandom_range(0, 3) == 0);
		end
		no_idle = 1'b0;
	endtask

	// Result side: random stall runs, plus the long hold-off when it is active.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_run == 0) begin
				if (no_idle) begin
					rx_stalling = 1'b0;
					rx_run = $urandom_range(1, 8);
				end else begin
					rx_stalling = ($urandom_range(0, 2) == 0);
					rx_run = rx_stalling ? idle_len() : $urandom_range(1, 20);
				end
			end
			rx_run--;
			out_stall <= hold_off || rx_stalling;
		end
	end

	// Long hold-off on results so the block backs up and stalls its request side.
	initial begin
		do @(posedge clk); while (mirror.accepted < 400);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Check every result the testbench takes.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.compare_reply(status, found_key, found_payload, entry_count);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		mirror = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		search_key = '0;
		entry_payload = '0;
		foreach (key_pool[i])
			key_pool[i] = rand64();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random();
		in_valid <= 1'b0;

		// Drain the outstanding results, then allow for one full scan more.
		while (mirror.due_replies.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mirror.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> keyed_overflow_table_core.f
rtl/kot_pkg.sv
rtl/kot_ram.sv
rtl/keyed_overflow_table_core.sv
dv/tb_keyed_overflow_table_core.sv
